// File: rtl/tac_pkg.sv
// tac_pkg: shared types, constants and the half-code table for the
// thermistor code to celsius converter. No dependencies.
package tac_pkg;

	localparam int STORED_POINTS         = 11;
	localparam int TABLE_ENTRIES_DEFAULT = 11;
	localparam int SEG_W                 = 4;
	localparam int HALF_W                = 8;
	localparam int NUM_W                 = 11;
	localparam int LIN_W                 = 11;
	localparam int LIN_SHIFT             = 5;
	localparam int DEG_W                 = LIN_W - LIN_SHIFT;
	localparam int FRAC_W                = 3;
	localparam int TEMP_W                = 8;

	localparam logic [9:0]       LINEAR_START_CODE = 10'd407;
	localparam logic [9:0]       HOT_LIMIT_CODE    = 10'd107;
	localparam logic [LIN_W-1:0] LIN_ROUND         = 11'd16;
	localparam logic [7:0]       BASE_TEMP         = 8'd50;
	localparam logic [7:0]       HOT_TEMP          = 8'd100;
	localparam int               STEP_DEG          = 5;

	typedef enum logic [1:0] {
		KIND_LINEAR,
		KIND_HOT,
		KIND_TABLE,
		KIND_NONE
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [SEG_W-1:0]   seg;
		logic [HALF_W-1:0]  half;
		logic [LIN_W-1:0]   lin_num;
	} s1_t;

	typedef struct packed {
		kind_t              kind;
		logic [SEG_W-1:0]   seg;
		logic [NUM_W-1:0]   num;
		logic [DEG_W-1:0]   lin_deg;
	} s2_t;

	// half-code at 50 C + 5 C * idx
	function automatic logic [HALF_W-1:0] half_code_at(input logic [SEG_W-1:0] idx);
		logic [HALF_W-1:0] v;
		case (idx)
			4'd0:    v = 8'd203;
			4'd1:    v = 8'd178;
			4'd2:    v = 8'd157;
			4'd3:    v = 8'd138;
			4'd4:    v = 8'd121;
			4'd5:    v = 8'd106;
			4'd6:    v = 8'd93;
			4'd7:    v = 8'd81;
			4'd8:    v = 8'd70;
			4'd9:    v = 8'd61;
			4'd10:   v = 8'd53;
			default: v = 8'd0;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/tac_classify.sv
// tac_classify: first pipeline stage, range decode, linear numerator and
// table segment search. Depends on tac_pkg.
module tac_classify #(
	parameter int TABLE_ENTRIES = tac_pkg::TABLE_ENTRIES_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [9:0]          adc_code,
	output logic                valid_s1,
	output tac_pkg::s1_t        data_s1
);
	import tac_pkg::*;

	localparam int USABLE = (TABLE_ENTRIES > STORED_POINTS) ? STORED_POINTS :
		(TABLE_ENTRIES < 1) ? 1 : TABLE_ENTRIES;

	s1_t               nxt;
	logic [9:0]        diff;
	logic [HALF_W-1:0] half;
	logic              found;
	logic [SEG_W-1:0]  seg;

	always_comb begin
		diff  = adc_code - LINEAR_START_CODE;
		half  = adc_code[8:1];
		found = 1'b0;
		seg   = '0;
		for (int i = STORED_POINTS - 2; i >= 0; i--) begin
			if ((i + 1 < USABLE) &&
			    (half_code_at(SEG_W'(i)) >= half) &&
			    (half_code_at(SEG_W'(i + 1)) < half)) begin
				found = 1'b1;
				seg   = SEG_W'(i);
			end
		end
		nxt.seg     = seg;
		nxt.half    = half;
		nxt.lin_num = {1'b0, diff} + {diff, 1'b0} + LIN_ROUND;
		if (adc_code >= LINEAR_START_CODE) begin
			nxt.kind = KIND_LINEAR;
		end else if (adc_code <= HOT_LIMIT_CODE) begin
			nxt.kind = KIND_HOT;
		end else if (found) begin
			nxt.kind = KIND_TABLE;
		end else begin
			nxt.kind = KIND_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		data_s1 <= nxt;
	end

endmodule

// File: rtl/tac_numerator.sv
// tac_numerator: second pipeline stage, interpolation numerator and
// linear degree count. Depends on tac_pkg.
module tac_numerator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  tac_pkg::s1_t        data_s1,
	output logic                valid_s2,
	output tac_pkg::s2_t        data_s2
);
	import tac_pkg::*;

	s2_t               nxt;
	logic [HALF_W-1:0] upper;
	logic [HALF_W-1:0] lower;
	logic [HALF_W-1:0] span;
	logic [NUM_W-1:0]  offset;

	always_comb begin
		upper       = half_code_at(data_s1.seg);
		lower       = half_code_at(data_s1.seg + SEG_W'(1));
		span        = upper - lower;
		offset      = NUM_W'(upper - data_s1.half);
		nxt.kind    = data_s1.kind;
		nxt.seg     = data_s1.seg;
		nxt.num     = offset + (offset << 2) + NUM_W'(span >> 1);
		nxt.lin_deg = data_s1.lin_num[LIN_W-1:LIN_SHIFT];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		data_s2 <= nxt;
	end

endmodule

// File: rtl/tac_result.sv
// tac_result: third pipeline stage, rounded quotient by threshold compare
// and final temperature select. Depends on tac_pkg.
module tac_result #(
	parameter int TABLE_ENTRIES = tac_pkg::TABLE_ENTRIES_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       valid_s2,
	input  tac_pkg::s2_t               data_s2,
	output logic                       valid_s3,
	output logic signed [tac_pkg::TEMP_W-1:0] temp_s3
);
	import tac_pkg::*;

	localparam int USABLE = (TABLE_ENTRIES > STORED_POINTS) ? STORED_POINTS :
		(TABLE_ENTRIES < 1) ? 1 : TABLE_ENTRIES;
	localparam logic [TEMP_W-1:0] LAST_TEMP = TEMP_W'(50 + STEP_DEG * (USABLE - 1));

	logic [HALF_W-1:0] span;
	logic [NUM_W-1:0]  step;
	logic [FRAC_W-1:0] frac;
	logic [TEMP_W-1:0] seg_deg;
	logic [TEMP_W-1:0] nxt;

	always_comb begin
		span = half_code_at(data_s2.seg) - half_code_at(data_s2.seg + SEG_W'(1));
		frac = '0;
		step = '0;
		for (int k = 1; k <= STEP_DEG; k++) begin
			step = step + NUM_W'(span);
			if (data_s2.num >= step) begin
				frac = FRAC_W'(k);
			end
		end
		seg_deg = {{(TEMP_W-SEG_W){1'b0}}, data_s2.seg};
		seg_deg = seg_deg + (seg_deg << 2);
		case (data_s2.kind)
			KIND_LINEAR: nxt = BASE_TEMP - {{(TEMP_W-DEG_W){1'b0}}, data_s2.lin_deg};
			KIND_HOT:    nxt = HOT_TEMP;
			KIND_TABLE:  nxt = BASE_TEMP + seg_deg + {{(TEMP_W-FRAC_W){1'b0}}, frac};
			KIND_NONE:   nxt = LAST_TEMP;
			default:     nxt = LAST_TEMP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		temp_s3 <= signed'(nxt);
	end

endmodule

// File: rtl/thermistor_adc_to_celsius.sv
// thermistor_adc_to_celsius: top level, adc code to whole degrees celsius.
// done follows start through the valid registers of the classify, numerator and result stages.
// Throughput one request per cycle; busy is always low, three register stages.
// Reset clears the stage valid bits only; no result is ever held back.
// Depends on tac_pkg, tac_classify, tac_numerator, tac_result.
module thermistor_adc_to_celsius #(
	parameter int TABLE_ENTRIES = tac_pkg::TABLE_ENTRIES_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [9:0]                        adc_code,
	output logic                              done,
	output logic signed [tac_pkg::TEMP_W-1:0] temp_celsius
);
	import tac_pkg::*;

	logic valid_s1;
	logic valid_s2;
	s1_t  data_s1;
	s2_t  data_s2;

	assign busy = 1'b0;

	tac_classify #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_classify (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start),
		.adc_code (adc_code),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	tac_numerator u_numerator (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2)
	);

	tac_result #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_result (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2),
		.valid_s3 (done),
		.temp_s3  (temp_celsius)
	);

endmodule
